### hw/rtl/rm2q_pkg.sv
// Package for the rotation matrix to quaternion converter.
// Holds the transaction payload types, field widths and branch codes; no dependencies.
package rm2q_pkg;

   localparam int DATA_W             = 16;
   localparam int FRAC_BITS_DEFAULT  = 14;
   localparam int QUOT_BITS          = 16;

   typedef enum logic [1:0] {
      SEL_W = 2'd0,
      SEL_X = 2'd1,
      SEL_Y = 2'd2,
      SEL_Z = 2'd3
   } sel_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m20;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
   } rm2q_in_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] qw;
      logic signed [DATA_W-1:0] qx;
      logic signed [DATA_W-1:0] qy;
      logic signed [DATA_W-1:0] qz;
      logic                     degenerate;
   } rm2q_out_type;

endpackage

### hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion converter, trace method, fully pipelined.
// Depends on rm2q_pkg for payload types and branch codes.
//
//   channel  ports                      handshake
//   input    start, busy, req_data      taken when start high and busy low
//   result   rsp_valid, rsp_data        one-cycle strobe, receiver cannot hold off
//
// One transaction enters every cycle; busy is never raised.
// Stages in order: input register, branch choice, one root bit per stage for
// the square root, divider set-up, then sixteen quotient-bit stages for the
// four dividers in parallel, then the output register.
// Synchronous reset clears the valid bits only; data registers run free.
module rotation_matrix_to_quaternion
   import rm2q_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  rm2q_in_type  req_data,
   output logic         rsp_valid,
   output rm2q_out_type rsp_data
);

   localparam int DIFF_W = DATA_W + 2;
   localparam int MAG_W  = DATA_W + 1;
   localparam int RW     = ((FRAC_BITS > MAG_W) ? FRAC_BITS : MAG_W) + 2;
   localparam int RSW    = RW + 1;
   localparam int SW     = (RW + FRAC_BITS + 3) / 2;
   localparam int NW     = 2 * SW;
   localparam int REMW   = SW + 2;
   localparam int DW     = MAG_W + FRAC_BITS + 1;
   localparam int CW     = ((DW > SW + QUOT_BITS) ? DW : SW + QUOT_BITS) + 1;
   localparam logic signed [RSW-1:0] ONE = RSW'(1) << FRAC_BITS;
   localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] NEG_MAG = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      sel_type                      sel;
      logic signed [RSW-1:0]        r;
      logic [3:0][DIFF_W-1:0]       d;
   } prep_type;

   typedef struct packed {
      sel_type                      sel;
      logic                         degen;
      logic [3:0][DIFF_W-1:0]       d;
   } side_type;

   typedef struct packed {
      sel_type                      sel;
      logic                         degen;
      logic [SW-1:0]                root;
      logic [3:0]                   neg;
      logic [3:0]                   ovf;
   } dside_type;

   assign busy = 1'b0;

   // ---------------- stage 0: input register
   rm2q_in_type in_ff;
   logic        in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_ff <= req_data;
   end

   // ---------------- stage 1: branch choice, radicand, pair sums
   prep_type prep_in;
   prep_type prep_ff;
   logic     prep_valid_ff;
   logic signed [RSW-1:0] e00, e11, e22, trace;
   logic signed [DIFF_W-1:0] d21m12, d02m20, d10m01, s01p10, s02p20, s12p21;

   assign e00    = RSW'(in_ff.m00);
   assign e11    = RSW'(in_ff.m11);
   assign e22    = RSW'(in_ff.m22);
   assign trace  = e00 + e11 + e22;
   assign d21m12 = DIFF_W'(in_ff.m21) - DIFF_W'(in_ff.m12);
   assign d02m20 = DIFF_W'(in_ff.m02) - DIFF_W'(in_ff.m20);
   assign d10m01 = DIFF_W'(in_ff.m10) - DIFF_W'(in_ff.m01);
   assign s01p10 = DIFF_W'(in_ff.m01) + DIFF_W'(in_ff.m10);
   assign s02p20 = DIFF_W'(in_ff.m02) + DIFF_W'(in_ff.m20);
   assign s12p21 = DIFF_W'(in_ff.m12) + DIFF_W'(in_ff.m21);

   always_comb begin
      prep_in = '0;
      if (trace > 0) begin
         prep_in.sel  = SEL_W;
         prep_in.r    = trace + ONE;
         prep_in.d[1] = d21m12;
         prep_in.d[2] = d02m20;
         prep_in.d[3] = d10m01;
      end else if (in_ff.m00 > in_ff.m11 && in_ff.m00 > in_ff.m22) begin
         prep_in.sel  = SEL_X;
         prep_in.r    = ONE + e00 - e11 - e22;
         prep_in.d[0] = d21m12;
         prep_in.d[2] = s01p10;
         prep_in.d[3] = s02p20;
      end else if (in_ff.m11 > in_ff.m22) begin
         prep_in.sel  = SEL_Y;
         prep_in.r    = ONE + e11 - e00 - e22;
         prep_in.d[0] = d02m20;
         prep_in.d[1] = s01p10;
         prep_in.d[3] = s12p21;
      end else begin
         prep_in.sel  = SEL_Z;
         prep_in.r    = ONE + e22 - e00 - e11;
         prep_in.d[0] = d10m01;
         prep_in.d[1] = s02p20;
         prep_in.d[2] = s12p21;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= in_valid_ff;
      end
      prep_ff <= prep_in;
   end

   // ---------------- square root, one root bit per stage
   side_type        seed_side;
   logic [NW-1:0]   seed_n;

   always_comb begin
      seed_side.sel   = prep_ff.sel;
      seed_side.degen = (prep_ff.r <= 0);
      seed_side.d     = prep_ff.d;
      seed_n          = NW'(prep_ff.r[RW-1:0]) << (FRAC_BITS + 2);
   end

   logic [REMW-1:0] sq_rem_ff   [SW];
   logic [SW-1:0]   sq_root_ff  [SW];
   logic [NW-1:0]   sq_n_ff     [SW];
   side_type        sq_side_ff  [SW];
   logic [SW-1:0]   sq_valid_ff;

   for (genvar i = 0; i < SW; i++) begin : g_sq
      logic [REMW-1:0] rem_src, rem_sh, trial, rem_in;
      logic [SW-1:0]   root_src, root_in;
      logic [NW-1:0]   n_src;
      side_type        side_src;
      logic            v_src;

      if (i == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign n_src    = seed_n;
         assign side_src = seed_side;
         assign v_src    = prep_valid_ff;
      end else begin : g_next
         assign rem_src  = sq_rem_ff[i-1];
         assign root_src = sq_root_ff[i-1];
         assign n_src    = sq_n_ff[i-1];
         assign side_src = sq_side_ff[i-1];
         assign v_src    = sq_valid_ff[i-1];
      end

      always_comb begin
         rem_sh = {rem_src[REMW-3:0], n_src[NW-1 -: 2]};
         trial  = {root_src, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_src[SW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_src[SW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[i] <= 1'b0;
         end else begin
            sq_valid_ff[i] <= v_src;
         end
         sq_rem_ff[i]  <= rem_in;
         sq_root_ff[i] <= root_in;
         sq_n_ff[i]    <= n_src << 2;
         sq_side_ff[i] <= side_src;
      end
   end

   // ---------------- divider set-up: rounding bias and overflow check
   side_type        sq_last;
   logic [SW-1:0]   s_root;
   dside_type       dset_in;
   logic [DW-1:0]   dset_rem_in [4];
   dside_type       dset_ff;
   logic [DW-1:0]   dset_rem_ff [4];
   logic            dset_valid_ff;

   assign sq_last = sq_side_ff[SW-1];
   assign s_root  = sq_root_ff[SW-1];

   always_comb begin
      logic signed [DIFF_W-1:0] dk;
      logic [MAG_W-1:0]         mag;
      logic [DW-1:0]            num;
      dset_in.sel   = sq_last.sel;
      dset_in.degen = sq_last.degen;
      dset_in.root  = s_root;
      for (int k = 0; k < 4; k++) begin
         dk  = $signed(sq_last.d[k]);
         mag = dk[DIFF_W-1] ? MAG_W'(-dk) : MAG_W'(dk);
         num = (DW'(mag) << FRAC_BITS) + DW'(s_root >> 1);
         dset_in.neg[k] = dk[DIFF_W-1];
         dset_in.ovf[k] = (num >> QUOT_BITS) >= DW'(s_root);
         dset_rem_in[k] = num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dset_valid_ff <= 1'b0;
      end else begin
         dset_valid_ff <= sq_valid_ff[SW-1];
      end
      dset_ff     <= dset_in;
      dset_rem_ff <= dset_rem_in;
   end

   // ---------------- four restoring dividers, one quotient bit per stage
   logic [DW-1:0]        dv_rem_ff  [QUOT_BITS][4];
   logic [QUOT_BITS-1:0] dv_q_ff    [QUOT_BITS][4];
   dside_type            dv_side_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0] dv_valid_ff;

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_dv
      logic [DW-1:0]        rem_src [4];
      logic [QUOT_BITS-1:0] q_src   [4];
      logic [DW-1:0]        rem_in  [4];
      logic [QUOT_BITS-1:0] q_in    [4];
      dside_type            side_src;
      logic                 v_src;

      if (j == 0) begin : g_first
         assign rem_src  = dset_rem_ff;
         assign q_src    = '{default: '0};
         assign side_src = dset_ff;
         assign v_src    = dset_valid_ff;
      end else begin : g_next
         assign rem_src  = dv_rem_ff[j-1];
         assign q_src    = dv_q_ff[j-1];
         assign side_src = dv_side_ff[j-1];
         assign v_src    = dv_valid_ff[j-1];
      end

      always_comb begin
         logic [CW-1:0] cmp;
         cmp = CW'(side_src.root) << (QUOT_BITS - 1 - j);
         for (int k = 0; k < 4; k++) begin
            if (CW'(rem_src[k]) >= cmp) begin
               rem_in[k] = DW'(CW'(rem_src[k]) - cmp);
               q_in[k]   = {q_src[k][QUOT_BITS-2:0], 1'b1};
            end else begin
               rem_in[k] = rem_src[k];
               q_in[k]   = {q_src[k][QUOT_BITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else begin
            dv_valid_ff[j] <= v_src;
         end
         dv_rem_ff[j]  <= rem_in;
         dv_q_ff[j]    <= q_in;
         dv_side_ff[j] <= side_src;
      end
   end

   // ---------------- output stage: pick, saturate, force zero on degenerate
   dside_type            dv_last;
   logic [SW:0]          quarter_s;
   logic [DATA_W-1:0]    comp [4];
   rm2q_out_type         rsp_data_in;
   rm2q_out_type         rsp_data_ff;
   logic                 rsp_valid_ff;

   assign dv_last   = dv_side_ff[QUOT_BITS-1];
   assign quarter_s = ((SW+1)'(dv_last.root) + (SW+1)'(2)) >> 2;

   always_comb begin
      logic [QUOT_BITS-1:0] q;
      for (int k = 0; k < 4; k++) begin
         q = dv_q_ff[QUOT_BITS-1][k];
         if (dv_last.sel == sel_type'(2'(k))) begin
            comp[k] = (quarter_s > (SW+1)'(POS_MAX)) ? POS_MAX : DATA_W'(quarter_s);
         end else if (dv_last.neg[k]) begin
            comp[k] = (dv_last.ovf[k] || q > NEG_MAG) ? NEG_MAG : DATA_W'(-q);
         end else begin
            comp[k] = (dv_last.ovf[k] || q > POS_MAX) ? POS_MAX : q;
         end
         if (dv_last.degen) begin
            comp[k] = '0;
         end
      end
      rsp_data_in.qw         = $signed(comp[0]);
      rsp_data_in.qx         = $signed(comp[1]);
      rsp_data_in.qy         = $signed(comp[2]);
      rsp_data_in.qz         = $signed(comp[3]);
      rsp_data_in.degenerate = dv_last.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid_ff[QUOT_BITS-1];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- checks
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.qw == 0 && rsp_data.qx == 0 && rsp_data.qy == 0 && rsp_data.qz == 0)
      else $error("degenerate transaction carries a non-zero component");

   a_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |->
         rsp_data.qw != 0 || rsp_data.qx != 0 || rsp_data.qy != 0 || rsp_data.qz != 0)
      else $error("valid transaction gave an all-zero quaternion");

endmodule

### bench/tb_rotation_matrix_to_quaternion.sv
// Self-checking bench for the rotation matrix to quaternion converter.
// Depends on rm2q_pkg and the rotation_matrix_to_quaternion RTL; drives a
// directed table, then random matrices, and checks each result against a predictor.
module tb_rotation_matrix_to_quaternion;
   import rm2q_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam int ONE = 1 << FRAC;
   localparam int N_RANDOM = 1750;
   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      rm2q_in_type  mat;
      logic         has_q;
      rm2q_out_type q;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   rm2q_in_type  req_data = '0;
   logic         rsp_valid;
   rm2q_out_type rsp_data;

   rm2q_out_type quat_queue[$];
   int           n_errors = 0;
   int           n_taken = 0;
   int           n_results = 0;
   int           n_degenerate = 0;
   int           idle_cycles = 0;
   int           gap_pct = 0;
   stim_row_type dir_table[$];

   rotation_matrix_to_quaternion uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   function automatic logic signed [15:0] sat16(logic neg, longint unsigned mag);
      if (neg) begin
         if (mag > 64'd32768) mag = 64'd32768;
         return 16'(-longint'(mag));
      end
      if (mag > 64'd32767) mag = 64'd32767;
      return 16'(mag);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root = 0;
      for (int b = 31; b >= 0; b--) begin
         longint unsigned t = root | (64'd1 << b);
         if (t * t <= n) root = t;
      end
      return root;
   endfunction

   function automatic logic signed [15:0] div_round(longint d, longint unsigned s);
      logic neg = d < 0;
      longint unsigned mag = neg ? longint'(-d) : longint'(d);
      return sat16(neg, ((mag << FRAC) + (s >> 1)) / s);
   endfunction

   function automatic rm2q_out_type matrix_to_quat(rm2q_in_type m);
      longint a00 = m.m00, a01 = m.m01, a02 = m.m02;
      longint a10 = m.m10, a11 = m.m11, a12 = m.m12;
      longint a20 = m.m20, a21 = m.m21, a22 = m.m22;
      longint tr = a00 + a11 + a22;
      longint rad;
      longint d[4];
      sel_type sel;
      longint unsigned s;
      logic signed [15:0] c[4];
      rm2q_out_type q;
      if (tr > 0) begin
         sel = SEL_W; rad = tr + ONE;
         d[1] = a21 - a12; d[2] = a02 - a20; d[3] = a10 - a01;
      end else if (a00 > a11 && a00 > a22) begin
         sel = SEL_X; rad = ONE + a00 - a11 - a22;
         d[0] = a21 - a12; d[2] = a01 + a10; d[3] = a02 + a20;
      end else if (a11 > a22) begin
         sel = SEL_Y; rad = ONE + a11 - a00 - a22;
         d[0] = a02 - a20; d[1] = a01 + a10; d[3] = a12 + a21;
      end else begin
         sel = SEL_Z; rad = ONE + a22 - a00 - a11;
         d[0] = a10 - a01; d[1] = a02 + a20; d[2] = a12 + a21;
      end
      q = '0;
      if (rad <= 0) begin
         q.degenerate = 1'b1;
         return q;
      end
      s = int_sqrt(longint'(rad) << (FRAC + 2));
      for (int k = 0; k < 4; k++)
         c[k] = (k == int'(sel)) ? sat16(1'b0, (s + 2) >> 2) : div_round(d[k], s);
      q.qw = c[0]; q.qx = c[1]; q.qy = c[2]; q.qz = c[3];
      return q;
   endfunction

   function automatic logic signed [15:0] rand_elem(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 2 * ONE) - ONE);
         default: return 16'($urandom_range(0, 800) - 400);
      endcase
   endfunction

   // Mostly in-range matrices, some small, some with wild 16-bit values; the
   // diagonal is biased per branch so every branch gets hit.
   function automatic rm2q_in_type rand_matrix();
      rm2q_in_type m;
      int mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
      int br = $urandom_range(0, 4);
      m.m01 = rand_elem(mode); m.m02 = rand_elem(mode); m.m10 = rand_elem(mode);
      m.m12 = rand_elem(mode); m.m20 = rand_elem(mode); m.m21 = rand_elem(mode);
      m.m00 = rand_elem(mode); m.m11 = rand_elem(mode); m.m22 = rand_elem(mode);
      case (br)
         1: begin m.m00 = 16'($urandom_range(0, ONE)); m.m11 = -m.m00; m.m22 = -m.m00; end
         2: begin m.m11 = 16'($urandom_range(0, ONE)); m.m00 = -m.m11; m.m22 = -m.m11; end
         3: begin m.m22 = 16'($urandom_range(0, ONE)); m.m00 = -m.m22; m.m11 = -m.m22; end
         4: begin m.m00 = -16'($urandom_range(0, ONE)); m.m11 = m.m00; m.m22 = m.m00; end
         default: ;
      endcase
      return m;
   endfunction

   function automatic rm2q_in_type diag_matrix(int a, int b, int c);
      rm2q_in_type m = '0;
      m.m00 = 16'(a); m.m11 = 16'(b); m.m22 = 16'(c);
      return m;
   endfunction

   task automatic add_row(rm2q_in_type m, logic known, rm2q_out_type q);
      stim_row_type r;
      r.mat = m; r.has_q = known; r.q = q;
      dir_table.push_back(r);
   endtask

   // Called at a falling edge; leaves start high so transactions can run back to back.
   task automatic send_matrix(rm2q_in_type m);
      while ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= m;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Record a transaction on the rising edge where it is taken.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         n_taken++;
      end
   end

   always @(posedge clock) begin
      rm2q_out_type want;
      if (!reset && rsp_valid) begin
         n_results++;
         if (quat_queue.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            n_errors++;
         end else begin
            want = quat_queue.pop_front();
            if (rsp_data.qw !== want.qw) begin
               $error("qw: expected %0d, got %0d", want.qw, rsp_data.qw); n_errors++;
            end
            if (rsp_data.qx !== want.qx) begin
               $error("qx: expected %0d, got %0d", want.qx, rsp_data.qx); n_errors++;
            end
            if (rsp_data.qy !== want.qy) begin
               $error("qy: expected %0d, got %0d", want.qy, rsp_data.qy); n_errors++;
            end
            if (rsp_data.qz !== want.qz) begin
               $error("qz: expected %0d, got %0d", want.qz, rsp_data.qz); n_errors++;
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $error("degenerate: expected %0b, got %0b", want.degenerate,
                      rsp_data.degenerate);
               n_errors++;
            end
            if (want.degenerate) n_degenerate++;
         end
      end
   end

   // Watchdog: count cycles with no transaction taken or delivered.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog expired");
         $display("** rotation_matrix_to_quaternion: FAILED **");
         $finish;
      end
   end

   initial begin
      rm2q_out_type q;
      rm2q_in_type m;
      int pct[4] = '{0, 51, 0, 21};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Identity gives w = 1; half-turns pick x, y and z; the rest go to the predictor.
      q = '0; q.qw = 16'(ONE);
      add_row(diag_matrix(ONE, ONE, ONE), 1'b1, q);
      q = '0; q.qx = 16'(ONE);
      add_row(diag_matrix(ONE, -ONE, -ONE), 1'b1, q);
      q = '0; q.qy = 16'(ONE);
      add_row(diag_matrix(-ONE, ONE, -ONE), 1'b1, q);
      q = '0; q.qz = 16'(ONE);
      add_row(diag_matrix(-ONE, -ONE, ONE), 1'b1, q);
      q = '0;
      add_row(diag_matrix(-ONE, -ONE, -ONE), 1'b0, q);
      add_row(diag_matrix(-32768, -32768, -32768), 1'b0, q);
      add_row(diag_matrix(0, 0, 0), 1'b0, q);
      add_row(diag_matrix(-ONE / 3, -ONE / 3, -ONE / 3), 1'b0, q);
      add_row(diag_matrix(32767, 32767, 32767), 1'b0, q);
      add_row(diag_matrix(32767, -32768, -32768), 1'b0, q);
      add_row(diag_matrix(5, 5, -10), 1'b0, q);
      add_row(diag_matrix(7, 7, 7), 1'b0, q);
      m = '1; add_row(m, 1'b0, q);
      m = '{default: 16'sh7fff}; add_row(m, 1'b0, q);
      m = '{default: -16'sh8000}; m.m00 = 1; add_row(m, 1'b0, q);
      m = diag_matrix(-ONE + 1, -ONE, -ONE);
      m.m01 = 32767; m.m10 = 32767; m.m02 = -32768; m.m20 = -32768;
      m.m12 = 32767; m.m21 = -32768;
      add_row(m, 1'b0, q);
      m.m00 = -ONE; m.m11 = -ONE + 1; add_row(m, 1'b0, q);
      m.m11 = -ONE; m.m22 = -ONE + 1; add_row(m, 1'b0, q);
      m = diag_matrix(1, 0, 0); m.m21 = 32767; m.m12 = -32768; add_row(m, 1'b0, q);

      foreach (dir_table[i]) begin
         q = matrix_to_quat(dir_table[i].mat);
         if (dir_table[i].has_q && q !== dir_table[i].q) begin
            $error("table row %0d: predictor gives %p, table %p", i, q, dir_table[i].q);
            n_errors++;
         end
         quat_queue.push_back(dir_table[i].has_q ? dir_table[i].q : q);
         send_matrix(dir_table[i].mat);
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         gap_pct = pct[(i * 4 / N_RANDOM) % 4];
         m = rand_matrix();
         quat_queue.push_back(matrix_to_quat(m));
         send_matrix(m);
      end
      start <= 1'b0;

      while (quat_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d matrices sent, %0d quaternions checked, %0d degenerate",
               n_taken, n_results, n_degenerate);
      $display("directed corner cases, all four branches and saturating extremes covered");
      if (n_errors == 0) begin
         $display("** rotation_matrix_to_quaternion: PASSED **");
      end else begin
         $display("** rotation_matrix_to_quaternion: FAILED **");
      end
      $finish;
   end
endmodule

### filelist.f
hw/rtl/rm2q_pkg.sv
hw/rtl/rotation_matrix_to_quaternion.sv
bench/tb_rotation_matrix_to_quaternion.sv
